// ===== sv/sst_pkg.sv =====
// Types and constants shared by the sorted span tracker.
// Holds the input and result transaction structs and the sequencer state enum.
// No dependencies.
`timescale 1ns / 1ps

package sst_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    localparam logic STATUS_ACCEPTED = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] copies;
    } sst_item_t;

    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] element_count;
        logic               spans_valid;
        logic [VALUE_W-1:0] shortest_span;
        logic [VALUE_W-1:0] longest_span;
    } sst_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_RD,
        ST_SHIFT_CHK,
        ST_FILL,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DONE
    } sst_state_t;

endpackage

// ===== sv/sorted_set_span_tracker.sv =====
// Sorted span tracker: bounded sorted multiset with shortest/longest span report.
// Depends on sst_pkg (types, state enum) and sst_ram (element store).
//
// Usage:
//   Configuration: cfg_data is the capacity limit, written when cfg_valid is
//   high (cfg_ready is always high). Write it only while busy is low.
//   Input: an item is taken at a clock edge with start high and busy low.
//   Result: one result per item, shown on result for the single cycle in which
//   done is high; the receiver cannot stall, so it must capture it then.
//   Steps: a query or rejected insert goes straight to done; an insert
//   moves any larger elements up, writes its n copies, then scans the
//   whole set for the spans.
//   Busy stays high until done has been shown; the next item can be taken
//   in the cycle after done. The cost is set by the single RAM port pair:
//   every moved element takes a read state and a compare state, and the gap scan
//   walks every held element through the one subtract and compare unit.
//   Reset empties the set and clears the capacity limit to zero, so every
//   insert is rejected until the limit has been written. No clearing pass.
`timescale 1ns / 1ps

module sorted_set_span_tracker
    import sst_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sst_item_t          item,
    output logic               done,
    output sst_result_t        result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SUM_W  = CNT_W + 8;

    sst_state_t state_reg, state_next;

    logic [COUNT_W-1:0]    limit_reg;
    logic [CNT_W-1:0]      held_reg, held_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;
    logic [ADDR_W-1:0]     pos_reg, pos_next;
    logic [COUNT_W-1:0]    n_reg, n_next;
    logic                  status_reg, status_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic [VALUE_BITS-1:0] gap_reg, gap_next;
    logic [VALUE_BITS-1:0] prev_reg, prev_next;
    logic [VALUE_BITS-1:0] first_reg, first_next;
    logic [VALUE_BITS-1:0] last_reg, last_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    logic                  accept;
    logic [SUM_W-1:0]      limit_eff;
    logic                  reject_now;
    logic                  idx_last;
    logic [VALUE_BITS-1:0] diff;

    sst_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshake and admission check
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign limit_eff = (SUM_W'(limit_reg) > SUM_W'(CAPACITY)) ? SUM_W'(CAPACITY)
                                                              : SUM_W'(limit_reg);
    assign reject_now = (SUM_W'(held_reg) + SUM_W'(item.copies)) > limit_eff;

    // gap subtract unit and scan end test
    assign diff     = ram_rdata - prev_reg;
    assign idx_last = (SUM_W'(idx_reg) + SUM_W'(1)) == SUM_W'(held_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.copies == '0 || reject_now)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (held_reg == '0)
                    begin
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                end
            end
            ST_SHIFT_RD:
            begin
                state_next = ST_SHIFT_CHK;
            end
            ST_SHIFT_CHK:
            begin
                if (ram_rdata > v_reg && idx_reg != '0)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (n_reg == COUNT_W'(1))
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                state_next = idx_last ? ST_DONE : ST_SCAN_RD;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        held_next   = held_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        n_next      = n_reg;
        status_next = status_reg;
        v_next      = v_reg;
        gap_next    = gap_reg;
        prev_next   = prev_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = v_reg;
        ram_raddr   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    v_next      = VALUE_BITS'(item.value);
                    n_next      = item.copies;
                    status_next = (item.copies != '0 && reject_now) ? STATUS_REJECTED
                                                                     : STATUS_ACCEPTED;
                    idx_next    = ADDR_W'(SUM_W'(held_reg) - SUM_W'(1));
                    pos_next    = '0;
                end
            end
            ST_SHIFT_RD:
            begin
                ram_raddr = idx_reg;
            end
            ST_SHIFT_CHK:
            begin
                // move larger entries up by the copy count, else mark the slot
                if (ram_rdata > v_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(SUM_W'(idx_reg) + SUM_W'(n_reg));
                    ram_wdata = ram_rdata;
                    pos_next  = idx_reg;
                    idx_next  = idx_reg - ADDR_W'(1);
                end
                else
                begin
                    pos_next = idx_reg + ADDR_W'(1);
                end
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = v_reg;
                pos_next  = pos_reg + ADDR_W'(1);
                n_next    = n_reg - COUNT_W'(1);
                held_next = held_reg + CNT_W'(1);
                idx_next  = '0;
                gap_next  = '1;
            end
            ST_SCAN_RD:
            begin
                ram_raddr = idx_reg;
            end
            ST_SCAN_CHK:
            begin
                // running minimum of neighbour differences
                prev_next = ram_rdata;
                idx_next  = idx_reg + ADDR_W'(1);
                if (idx_reg == '0)
                begin
                    first_next = ram_rdata;
                end
                else if (diff < gap_reg)
                begin
                    gap_next = diff;
                end
                if (idx_last)
                begin
                    last_next = ram_rdata;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // result outputs
    always_comb
    begin
        done                 = (state_reg == ST_DONE);
        result.status        = status_reg;
        result.element_count = COUNT_W'(held_reg);
        result.spans_valid   = (held_reg > CNT_W'(1));
        result.shortest_span = result.spans_valid ? VALUE_W'(gap_reg) : '0;
        result.longest_span  = result.spans_valid ? VALUE_W'(last_reg - first_reg) : '0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            held_reg  <= '0;
            limit_reg <= '0;
            n_reg     <= '0;
            idx_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            n_reg     <= n_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        v_reg      <= v_next;
        gap_reg    <= gap_next;
        prev_reg   <= prev_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
    end

`ifndef NO_ASSERTIONS
    // the held count never passes the store depth
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(held_reg) <= SUM_W'(CAPACITY))
        else $error("held count exceeds store depth");

    // each fill write stays inside the effective limit
    a_fill_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (SUM_W'(held_reg) + SUM_W'(1) <= limit_eff))
        else $error("fill beyond capacity limit");

    // queries and rejected inserts answer in the next cycle
    a_fast_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.copies == '0 || reject_now)) |=> (done && $stable(held_reg)))
        else $error("query or reject did not answer at once");

    // a rejected result never changes the element count
    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == STATUS_REJECTED) |-> (held_reg == $past(held_reg)))
        else $error("rejected item changed the store");

    // after a result the block is free again
    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy held after result");
`endif

endmodule

// ===== sv/sst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the sorted element store. No dependencies.
`timescale 1ns / 1ps

module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
